// ===== rtl/pulse_rate_speed_regulator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse-rate speed regulator.
// Define NO_ASSERTIONS to compile every assertion away.
// ----------------------------------------------------------------------------
`ifndef PULSE_RATE_SPEED_REGULATOR_MACROS_SVH
`define PULSE_RATE_SPEED_REGULATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PRSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PRSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PRSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/prsr_pkg.sv =====
// ----------------------------------------------------------------------------
// prsr_pkg
// Types, codes and constants shared by the speed regulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prsr_pkg;

  localparam int NUM_MOTORS_DEF = 2;

  localparam logic [15:0] ADJUST_GAP_RST = 16'd20;
  localparam logic [15:0] STALL_GAP_RST  = 16'd150;
  localparam logic [6:0]  BOOST_STEP_RST = 7'd5;

  localparam logic signed [7:0] DELTA_DEC = -8'sd1;
  localparam logic signed [7:0] DELTA_INC = 8'sd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PULSE = 2'd1,
    OP_LOAD  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ACT_ADJUST = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_START  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    CFG_ADJUST_GAP = 2'd0,
    CFG_STALL_GAP  = 2'd1,
    CFG_BOOST_STEP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] adjust_gap;
    logic [15:0] stall_gap;
    logic [6:0]  boost_step;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        motor;
    logic [15:0] pulse_budget;
    logic [15:0] pulse_spacing;
    logic        direction;
  } item_t;

  typedef struct packed {
    logic              motor;
    act_e              action;
    logic signed [7:0] delta;
    logic              dir;
    logic              last;
  } result_t;

  // Up to two results written into the queue in one cycle, in order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room2;
  } fifo_status_t;

  // Time from b to a; one short of the modular distance when the counter wrapped.
  function automatic logic [15:0] elapsed(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    if (a < b) begin
      d = d - 16'd1;
    end
    return d;
  endfunction

  function automatic result_t make_result(input logic m, input act_e act,
                                          input logic signed [7:0] dl, input logic dr);
    result_t r;
    r.motor  = m;
    r.action = act;
    r.delta  = dl;
    r.dir    = dr;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/prsr_core.sv =====
// ----------------------------------------------------------------------------
// prsr_core
// Motor state and the per-item regulation logic; one item per cycle while fire_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prsr_core #(
  parameter int NUM_MOTORS = prsr_pkg::NUM_MOTORS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  prsr_pkg::item_t item_i,
  input  prsr_pkg::cfg_t  cfg_i,
  output prsr_pkg::push_t push_o
);

  localparam int IdxW   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int NumChk = (NUM_MOTORS < 2) ? NUM_MOTORS : 2;

  logic [15:0] time_q, time_d;
  logic [15:0] lpt_q [NUM_MOTORS];
  logic [15:0] lpt_d [NUM_MOTORS];
  logic [15:0] lct_q [NUM_MOTORS];
  logic [15:0] lct_d [NUM_MOTORS];
  logic [15:0] left_q [NUM_MOTORS];
  logic [15:0] left_d [NUM_MOTORS];
  logic [15:0] exp_q [NUM_MOTORS];
  logic [15:0] exp_d [NUM_MOTORS];

  logic [15:0]     time_inc;
  logic [1:0]      chk_upd;
  logic [1:0]      chk_boost;
  prsr_pkg::result_t boost_res [2];

  assign time_inc = time_q + 16'd1;

  // Stall check for the first two motors, evaluated at the incremented time.
  for (genvar k = 0; k < 2; k++) begin : g_chk
    if (k < NumChk) begin : g_on
      assign chk_upd[k] = (left_q[k] != 16'd0) &&
                          (prsr_pkg::elapsed(time_inc, lct_q[k]) > cfg_i.stall_gap);
      assign chk_boost[k] = chk_upd[k] &&
                            (prsr_pkg::elapsed(time_inc, lpt_q[k]) > exp_q[k]);
    end else begin : g_off
      assign chk_upd[k]   = 1'b0;
      assign chk_boost[k] = 1'b0;
    end
    assign boost_res[k] = prsr_pkg::make_result(1'(k), prsr_pkg::ACT_ADJUST,
                                                signed'({1'b0, cfg_i.boost_step}), 1'b0);
  end

  logic [IdxW-1:0] midx;
  logic            in_range;
  logic [15:0]     diff;
  logic [15:0]     cur_lpt, cur_lct, cur_left, cur_exp;

  assign midx     = IdxW'(item_i.motor);
  assign in_range = ({31'b0, item_i.motor} < 32'(NUM_MOTORS));
  assign cur_lpt  = lpt_q[midx];
  assign cur_lct  = lct_q[midx];
  assign cur_left = left_q[midx];
  assign cur_exp  = exp_q[midx];
  assign diff     = prsr_pkg::elapsed(time_q, cur_lpt);

  always_comb begin
    time_d = time_q;
    lpt_d  = lpt_q;
    lct_d  = lct_q;
    left_d = left_q;
    exp_d  = exp_q;
    push_o = '0;
    if (fire_i) begin
      case (item_i.op)
        prsr_pkg::OP_TICK: begin
          time_d = time_inc;
          if (time_inc[7:0] == 8'd0) begin
            for (int k = 0; k < NumChk; k++) begin
              if (chk_upd[k]) begin
                lct_d[k] = time_inc;
              end
            end
            push_o.cnt = 2'(chk_boost[0]) + 2'(chk_boost[1]);
            push_o.r0  = chk_boost[0] ? boost_res[0] : boost_res[1];
            push_o.r1  = boost_res[1];
            if (push_o.cnt == 2'd1) begin
              push_o.r0.last = 1'b1;
            end else if (push_o.cnt == 2'd2) begin
              push_o.r1.last = 1'b1;
            end
          end
        end
        prsr_pkg::OP_PULSE: begin
          if (in_range) begin
            lpt_d[midx] = time_q;
            if (cur_left == 16'd0) begin
              push_o.cnt     = 2'd1;
              push_o.r0      = prsr_pkg::make_result(item_i.motor, prsr_pkg::ACT_STOP,
                                                     8'sd0, 1'b0);
              push_o.r0.last = 1'b1;
            end else begin
              left_d[midx] = cur_left - 16'd1;
              if ((prsr_pkg::elapsed(time_q, cur_lct) > cfg_i.adjust_gap) &&
                  (diff != cur_exp)) begin
                push_o.cnt     = 2'd1;
                push_o.r0      = prsr_pkg::make_result(item_i.motor, prsr_pkg::ACT_ADJUST,
                                   (diff < cur_exp) ? prsr_pkg::DELTA_DEC
                                                    : prsr_pkg::DELTA_INC, 1'b0);
                push_o.r0.last = 1'b1;
                lct_d[midx]    = time_q;
              end
            end
          end
        end
        prsr_pkg::OP_LOAD: begin
          if (in_range) begin
            exp_d[midx]    = item_i.pulse_spacing;
            left_d[midx]   = item_i.pulse_budget;
            push_o.cnt     = 2'd1;
            push_o.r0      = prsr_pkg::make_result(item_i.motor, prsr_pkg::ACT_START,
                                                   8'sd0, item_i.direction);
            push_o.r0.last = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        lpt_q[i]  <= '0;
        lct_q[i]  <= '0;
        left_q[i] <= '0;
        exp_q[i]  <= '0;
      end
    end else begin
      time_q <= time_d;
      lpt_q  <= lpt_d;
      lct_q  <= lct_d;
      left_q <= left_d;
      exp_q  <= exp_d;
    end
  end

endmodule

// ===== rtl/prsr_fifo.sv =====
// ----------------------------------------------------------------------------
// prsr_fifo
// Result queue taking up to two results a cycle and giving one a cycle whenever popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prsr_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prsr_pkg::push_t        push_i,
  input  logic                   pop_i,
  output prsr_pkg::result_t      head_o,
  output prsr_pkg::fifo_status_t status_o
);

  localparam int PtrW = prsr_pkg::FIFO_PTR_W;
  localparam int CntW = prsr_pkg::FIFO_CNT_W;

  prsr_pkg::result_t mem_q [prsr_pkg::FIFO_DEPTH];

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.cnt);
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.count = cnt_q;
  // Room for a full tick's worth of results.
  assign status_o.room2 = (cnt_q <= CntW'(prsr_pkg::FIFO_DEPTH - 2));

endmodule

// ===== rtl/pulse_rate_speed_regulator.sv =====
// ----------------------------------------------------------------------------
// pulse_rate_speed_regulator: per-motor bang-bang speed regulator.
// An accepted item is held in the input register, goes to the core once the
// queue has room for two results; the results wait in it. One item a cycle,
// bounded by the one-result-a-cycle output queue; ticks may yield two. Reset
// is immediate: time and motor state clear to zero, registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pulse_rate_speed_regulator_macros.svh"

module pulse_rate_speed_regulator #(
  parameter int NUM_MOTORS = prsr_pkg::NUM_MOTORS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic              motor_i,
  input  logic [15:0]       pulse_budget_i,
  input  logic [15:0]       pulse_spacing_i,
  input  logic              direction_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              target_motor_o,
  output logic [1:0]        action_o,
  output logic signed [7:0] delta_o,
  output logic              start_direction_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  prsr_pkg::cfg_t         cfg_q;
  prsr_pkg::item_t        item_q;
  logic                   in_vld_q, in_vld_d;
  logic                   accept, consume, pop;
  prsr_pkg::push_t        push;
  prsr_pkg::result_t      head;
  prsr_pkg::fifo_status_t fifo_st;

  // Configuration register file; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adjust_gap <= prsr_pkg::ADJUST_GAP_RST;
      cfg_q.stall_gap  <= prsr_pkg::STALL_GAP_RST;
      cfg_q.boost_step <= prsr_pkg::BOOST_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        prsr_pkg::CFG_ADJUST_GAP: cfg_q.adjust_gap <= cfg_data_i;
        prsr_pkg::CFG_STALL_GAP:  cfg_q.stall_gap  <= cfg_data_i;
        prsr_pkg::CFG_BOOST_STEP: cfg_q.boost_step <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: the held item moves on once the queue can take two results.
  assign consume    = in_vld_q && fifo_st.room2;
  assign in_stall_o = in_vld_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (consume) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op            <= op_i;
      item_q.motor         <= motor_i;
      item_q.pulse_budget  <= pulse_budget_i;
      item_q.pulse_spacing <= pulse_spacing_i;
      item_q.direction     <= direction_i;
    end
  end

  prsr_core #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(consume),
    .item_i(item_q),
    .cfg_i (cfg_q),
    .push_o(push)
  );

  assign pop = out_valid_o && !out_stall_i;

  prsr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(fifo_st)
  );

  assign out_valid_o       = (fifo_st.count != '0);
  assign target_motor_o    = head.motor;
  assign action_o          = head.action;
  assign delta_o           = head.delta;
  assign start_direction_o = head.dir;
  assign last_o            = head.last;

  `PRSR_ASSERT_IMPL(a_consume_room, clk_i, rst_ni, consume,
                    fifo_st.count <= prsr_pkg::FIFO_CNT_W'(prsr_pkg::FIFO_DEPTH - 2),
                    "item processed without room for its results")
  `PRSR_ASSERT_IMPL(a_push_only_on_fire, clk_i, rst_ni, push.cnt != 2'd0, consume,
                    "results queued with no item processed")
  `PRSR_ASSERT_NEXT(a_held_item_stays, clk_i, rst_ni, in_vld_q && !consume, in_vld_q,
                    "held input item dropped without processing")

endmodule

// ===== dv/pulse_rate_speed_regulator_test.sv =====
// ----------------------------------------------------------------------------
// pulse_rate_speed_regulator_test
// Self-checking bench for the speed regulator. Ticks, encoder pulses and
// motion loads are driven with random idling on both sides. A scoreboard
// class keeps its own copy of the time counter and motor state and predicts
// every drive command. Each command that leaves the block is checked in
// order against those predictions. The register settings include the
// extremes, and the time counter passes several stall-check points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_rate_speed_regulator_test;

  localparam int          CLK_PERIOD    = 10;
  localparam int          MOTORS        = prsr_pkg::NUM_MOTORS_DEF;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned LIMIT_CYCLES  = 100_000;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [1:0]  CFG_NONE      = 2'd3;

  typedef struct packed {
    logic              motor;
    logic [1:0]        action;
    logic signed [7:0] delta;
    logic              dir;
    logic              last;
  } drive_cmd_t;

  class drive_command_board;
    logic [15:0] adjust_gap;
    logic [15:0] stall_gap;
    logic [6:0]  boost_step;
    logic [15:0] now;
    logic [15:0] last_pulse  [MOTORS];
    logic [15:0] last_change [MOTORS];
    logic [15:0] pulses_left [MOTORS];
    logic [15:0] spacing     [MOTORS];
    drive_cmd_t  pending_cmds [$];
    int          errors;

    function new();
      adjust_gap = prsr_pkg::ADJUST_GAP_RST;
      stall_gap  = prsr_pkg::STALL_GAP_RST;
      boost_step = prsr_pkg::BOOST_STEP_RST;
      now        = '0;
      errors     = 0;
      foreach (last_pulse[k]) begin
        last_pulse[k]  = '0;
        last_change[k] = '0;
        pulses_left[k] = '0;
        spacing[k]     = '0;
      end
    endfunction

    // Time from b to a. Across a wrap this comes out one short of the true
    // distance, which is how the block counts it.
    function logic [15:0] since(input logic [15:0] a, input logic [15:0] b);
      if (a >= b) begin
        return a - b;
      end
      return a + (16'hFFFF - b);
    endfunction

    function drive_cmd_t command(input logic m, input logic [1:0] act,
                                 input logic signed [7:0] d, input logic dr);
      drive_cmd_t c;
      c.motor  = m;
      c.action = act;
      c.delta  = d;
      c.dir    = dr;
      c.last   = 1'b0;
      return c;
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        prsr_pkg::CFG_ADJUST_GAP: adjust_gap = data;
        prsr_pkg::CFG_STALL_GAP:  stall_gap  = data;
        prsr_pkg::CFG_BOOST_STEP: boost_step = data[6:0];
        default: ;
      endcase
    endfunction

    // Works out the commands that one accepted item causes.
    function void note_item(input logic [1:0] op, input logic m, input logic [15:0] budget,
                            input logic [15:0] spc, input logic dir);
      drive_cmd_t  fresh [$];
      logic [15:0] prev;
      logic [15:0] gap;
      case (op)
        prsr_pkg::OP_TICK: begin
          now = now + 16'd1;
          if (now[7:0] == 8'd0) begin
            for (int k = 0; k < MOTORS; k++) begin
              if (pulses_left[k] != 16'd0 && since(now, last_change[k]) > stall_gap) begin
                if (since(now, last_pulse[k]) > spacing[k]) begin
                  fresh.push_back(command(k[0], prsr_pkg::ACT_ADJUST,
                                          $signed({1'b0, boost_step}), 1'b0));
                end
                // The check counts as a change even when no boost is due.
                last_change[k] = now;
              end
            end
          end
        end
        prsr_pkg::OP_PULSE: begin
          prev          = last_pulse[m];
          last_pulse[m] = now;
          if (pulses_left[m] == 16'd0) begin
            fresh.push_back(command(m, prsr_pkg::ACT_STOP, 8'sd0, 1'b0));
          end else begin
            pulses_left[m] = pulses_left[m] - 16'd1;
            gap            = since(now, prev);
            if (since(now, last_change[m]) > adjust_gap && gap != spacing[m]) begin
              fresh.push_back(command(m, prsr_pkg::ACT_ADJUST,
                                      (gap < spacing[m]) ? prsr_pkg::DELTA_DEC
                                                         : prsr_pkg::DELTA_INC, 1'b0));
              last_change[m] = now;
            end
          end
        end
        prsr_pkg::OP_LOAD: begin
          spacing[m]     = spc;
          pulses_left[m] = budget;
          fresh.push_back(command(m, prsr_pkg::ACT_START, 8'sd0, dir));
        end
        default: ;
      endcase
      if (fresh.size() > 0) begin
        fresh[fresh.size() - 1].last = 1'b1;
      end
      foreach (fresh[i]) begin
        pending_cmds.push_back(fresh[i]);
      end
    endfunction

    function void check_result(input drive_cmd_t got);
      drive_cmd_t want;
      if (pending_cmds.size() == 0) begin
        flag($sformatf("unexpected command: motor %0d action %0d delta %0d dir %0d last %0d",
                       got.motor, got.action, got.delta, got.dir, got.last));
        return;
      end
      want = pending_cmds.pop_front();
      if (got !== want) begin
        flag($sformatf({"command mismatch: expected motor %0d action %0d delta %0d dir %0d ",
                        "last %0d, got motor %0d action %0d delta %0d dir %0d last %0d"},
                       want.motor, want.action, want.delta, want.dir, want.last,
                       got.motor, got.action, got.delta, got.dir, got.last));
      end
    endfunction

    function void close_out();
      while (pending_cmds.size() > 0) begin
        void'(pending_cmds.pop_front());
        flag("predicted command never arrived");
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        op_i;
  logic              motor_i;
  logic [15:0]       pulse_budget_i;
  logic [15:0]       pulse_spacing_i;
  logic              direction_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              target_motor_o;
  logic [1:0]        action_o;
  logic signed [7:0] delta_o;
  logic              start_direction_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;

  drive_command_board board = new();
  bit                 quiet;
  int                 hold_req;
  int unsigned        cycle_count = 0;

  pulse_rate_speed_regulator u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .motor_i          (motor_i),
    .pulse_budget_i   (pulse_budget_i),
    .pulse_spacing_i  (pulse_spacing_i),
    .direction_i      (direction_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_motor_o   (target_motor_o),
    .action_o         (action_o),
    .delta_o          (delta_o),
    .start_direction_o(start_direction_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result('{motor: target_motor_o, action: action_o, delta: delta_o,
                           dir: start_direction_o, last: last_o});
    end
  end

  // Result side. A change of hold_req starts a long hold-off so that the
  // output queue fills and the block has to stall its input.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < 32);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] op, input logic m, input logic [15:0] budget,
                           input logic [15:0] spc, input logic dir);
    while (!quiet && $urandom_range(99) < 32) @(negedge clk_i);
    in_valid_i      = 1'b1;
    op_i            = op;
    motor_i         = m;
    pulse_budget_i  = budget;
    pulse_spacing_i = spc;
    direction_i     = dir;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(op, m, budget, spc, dir);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_tick();
    send_item(prsr_pkg::OP_TICK, 1'($urandom_range(1)), 16'($urandom), 16'($urandom),
              1'($urandom_range(1)));
  endtask

  task automatic send_pulse(input logic m);
    send_item(prsr_pkg::OP_PULSE, m, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
  endtask

  // Waits until every predicted command has arrived and the last item has
  // had time to work through the block.
  task automatic settle();
    while (board.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] adj, input logic [15:0] stl,
                          input logic [6:0] boost);
    settle();
    write_reg(prsr_pkg::CFG_ADJUST_GAP, adj);
    write_reg(prsr_pkg::CFG_STALL_GAP, stl);
    write_reg(prsr_pkg::CFG_BOOST_STEP, {9'd0, boost});
  endtask

  task automatic run_random(input int events);
    int          pick;
    int          len;
    int          gap;
    logic        m;
    logic [15:0] budget;
    logic [15:0] spc;
    for (int i = 0; i < events; i++) begin
      pick = int'($urandom_range(99));
      m    = 1'($urandom_range(1));
      if (pick < 30) begin
        len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 60))
                                       : int'($urandom_range(1, 8));
        repeat (len) send_tick();
      end else if (pick < 62) begin
        send_pulse(m);
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:       budget = 16'hFFFF;
          1:       budget = 16'($urandom);
          default: budget = 16'($urandom_range(0, 12));
        endcase
        case ($urandom_range(9))
          0:       spc = 16'hFFFF;
          1:       spc = 16'($urandom);
          default: spc = 16'($urandom_range(0, 24));
        endcase
        send_item(prsr_pkg::OP_LOAD, m, budget, spc, 1'($urandom_range(1)));
      end else if (pick < 86) begin
        send_item(OP_UNUSED, m, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
      end else begin
        // A whole move: load, pulses near the expected spacing, then run
        // past the budget so that the motor is stopped.
        budget = 16'($urandom_range(1, 6));
        spc    = 16'($urandom_range(1, 8));
        send_item(prsr_pkg::OP_LOAD, m, budget, spc, 1'($urandom_range(1)));
        repeat (int'(budget) + int'($urandom_range(1, 2))) begin
          gap = int'(spc) + int'($urandom_range(4)) - 2;
          if (gap < 0) begin
            gap = 0;
          end
          repeat (gap) send_tick();
          send_pulse(m);
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = prsr_pkg::OP_TICK;
    motor_i         = 1'b0;
    pulse_budget_i  = '0;
    pulse_spacing_i = '0;
    direction_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = prsr_pkg::CFG_ADJUST_GAP;
    cfg_data_i      = '0;
    quiet           = 1'b0;
    hold_req        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset register values.
    send_item(OP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pulse(1'b0);
    send_pulse(1'b1);
    send_item(prsr_pkg::OP_LOAD, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(prsr_pkg::OP_LOAD, 1'b1, 16'd2, 16'd0, 1'b0);
    send_item(prsr_pkg::OP_LOAD, 1'b0, 16'd0, 16'd0, 1'b0);
    send_pulse(1'b0);
    send_item(prsr_pkg::OP_LOAD, 1'b0, 16'hFFFF, 16'd5, 1'b1);
    repeat (3) send_tick();
    repeat (3) send_pulse(1'b1);
    repeat (2) send_pulse(1'b0);
    send_item(prsr_pkg::OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);

    // Every pulse may adjust and every stall check may boost.
    set_regs(16'd0, 16'd0, 7'd127);
    run_random(50);

    // Gaps that can never be exceeded: only starts and stops remain.
    set_regs(16'hFFFF, 16'hFFFF, 7'd0);
    write_reg(CFG_NONE, 16'($urandom));
    quiet = 1'b1;
    run_random(30);
    quiet = 1'b0;

    set_regs(16'($urandom_range(0, 40)), 16'($urandom_range(0, 600)),
             7'($urandom_range(1, 126)));
    hold_req++;
    run_random(50);
    settle();
    hold_req++;
    run_random(50);

    settle();
    board.close_out();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
